@@ rtl/sprite_alpha_trim_and_pivot_macros.svh @@
// Assertion macros shared by the sprite trim and pivot RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SPRITE_ALPHA_TRIM_AND_PIVOT_MACROS_SVH
`define SPRITE_ALPHA_TRIM_AND_PIVOT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SATP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SATP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/satp_pkg.sv @@
// Shared types and constants for the sprite alpha trim and pivot block.
// No dependencies; every RTL module imports this package.
package satp_pkg;

  // Default for the largest supported image dimension.
  localparam int MAX_IMAGE_DIM_DEF = 4096;

  // Field widths fixed by the interface.
  localparam int ALPHA_W  = 8;
  localparam int DIM_W    = 13;
  localparam int COORD_W  = 12;
  localparam int PIVOT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_W_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_H_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEN_PIVOT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEN_PIVOT_Y = 3'd5;

  // Register values after reset.
  localparam logic [MODE_W-1:0] RST_PIVOT_MODE = 2'd0;
  localparam logic [DIM_W-1:0]  RST_DIM        = 13'd256;

  // Pivot modes.
  localparam logic [MODE_W-1:0] PM_GIVEN     = 2'd0;
  localparam logic [MODE_W-1:0] PM_BRICKS    = 2'd1;
  localparam logic [MODE_W-1:0] PM_LOWER_MID = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

  // One incoming pixel.
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               end_of_image;
  } pixel_t;

  // One trim result.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [COORD_W-1:0]        box_left;
    logic [COORD_W-1:0]        box_top;
    logic [DIM_W-1:0]          box_width;
    logic [DIM_W-1:0]          box_height;
    logic signed [PIVOT_W-1:0] pivot_x;
    logic signed [PIVOT_W-1:0] pivot_y;
  } result_t;

  // Current configuration register contents.
  typedef struct packed {
    logic [MODE_W-1:0]         pivot_mode;
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          texture_width_limit;
    logic [DIM_W-1:0]          texture_height_limit;
    logic signed [PIVOT_W-1:0] given_pivot_x;
    logic signed [PIVOT_W-1:0] given_pivot_y;
  } cfg_t;

endpackage

@@ rtl/satp_cfg.sv @@
// Configuration register file for the sprite trim and pivot block.
// Depends on satp_pkg for the register indexes, reset values and cfg_t.
module satp_cfg
  import satp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  // Register writes, each register keeping the low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pivot_mode           <= RST_PIVOT_MODE;
      cfg.image_width          <= RST_DIM;
      cfg.texture_width_limit  <= RST_DIM;
      cfg.texture_height_limit <= RST_DIM;
      cfg.given_pivot_x        <= '0;
      cfg.given_pivot_y        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIVOT_MODE:    cfg.pivot_mode           <= cfg_data[MODE_W-1:0];
        CFG_IMAGE_WIDTH:   cfg.image_width          <= cfg_data[DIM_W-1:0];
        CFG_TEX_W_LIMIT:   cfg.texture_width_limit  <= cfg_data[DIM_W-1:0];
        CFG_TEX_H_LIMIT:   cfg.texture_height_limit <= cfg_data[DIM_W-1:0];
        CFG_GIVEN_PIVOT_X: cfg.given_pivot_x        <= cfg_data;
        CFG_GIVEN_PIVOT_Y: cfg.given_pivot_y        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/satp_track.sv @@
// Pixel input register, raster counters and bounding box tracking.
// Depends on satp_pkg and on the assertion macros header.
`include "sprite_alpha_trim_and_pivot_macros.svh"
module satp_track
  import satp_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF,
  parameter int CW            = $clog2(MAX_IMAGE_DIM),
  parameter int EW            = CW + 1
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  pixel_t        pix,
  input  cfg_t          cfg,
  input  logic          out_free,
  output logic          fire,
  output logic          upd_has,
  output logic [CW-1:0] upd_min_col,
  output logic [CW-1:0] upd_max_col,
  output logic [CW-1:0] upd_min_row,
  output logic [CW-1:0] upd_max_row,
  output logic [CW-1:0] upd_brick_row,
  output logic [EW-1:0] w_eff
);

  localparam int XW = (EW > DIM_W) ? EW : DIM_W;

  logic          s1_valid;
  pixel_t        s1_pix;
  logic          s1_go;
  logic          accept;
  logic          opaque;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] min_column;
  logic [CW-1:0] max_column;
  logic [CW-1:0] min_row;
  logic [CW-1:0] max_row;
  logic          has_content;
  logic [CW-1:0] brick_pivot_row;

  logic [XW-1:0] w_ext;
  logic [XW-1:0] w_clamp;
  logic [EW-1:0] col_inc;
  logic          wrap;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;

  // The held pixel moves on unless it ends an image and the result slot is busy.
  assign s1_go     = s1_valid && (!s1_pix.end_of_image || out_free);
  assign pix_stall = s1_valid && !s1_go;
  assign accept    = pix_valid && !pix_stall;
  assign fire      = s1_go && s1_pix.end_of_image;

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix;
    end
  end

  // Effective width: zero acts as one, and the width is capped at the maximum.
  assign w_ext = XW'(cfg.image_width);
  always_comb begin
    if (w_ext == '0) begin
      w_clamp = XW'(1);
    end else if (w_ext > XW'(MAX_IMAGE_DIM)) begin
      w_clamp = XW'(MAX_IMAGE_DIM);
    end else begin
      w_clamp = w_ext;
    end
  end
  assign w_eff = w_clamp[EW-1:0];

  // Raster counters; the row count saturates at the last row.
  assign col_inc = {1'b0, column_count} + EW'(1);
  assign wrap    = (col_inc >= w_eff);
  always_comb begin
    if (wrap) begin
      column_count_next = '0;
      if (row_count != CW'(MAX_IMAGE_DIM - 1)) begin
        row_count_next = row_count + CW'(1);
      end else begin
        row_count_next = row_count;
      end
    end else begin
      column_count_next = col_inc[CW-1:0];
      row_count_next    = row_count;
    end
  end

  // Bounding box update with the held pixel.
  assign opaque = (s1_pix.alpha != '0);
  always_comb begin
    upd_has       = has_content;
    upd_min_col   = min_column;
    upd_max_col   = max_column;
    upd_min_row   = min_row;
    upd_max_row   = max_row;
    upd_brick_row = brick_pivot_row;
    if (opaque) begin
      upd_has = 1'b1;
      if (!has_content || column_count < min_column) begin
        upd_min_col   = column_count;
        upd_brick_row = row_count;
      end else if (column_count == min_column) begin
        upd_brick_row = row_count;
      end
      if (!has_content || column_count > max_column) begin
        upd_max_col = column_count;
      end
      if (!has_content || row_count < min_row) begin
        upd_min_row = row_count;
      end
      if (!has_content || row_count > max_row) begin
        upd_max_row = row_count;
      end
    end
  end

  // Tracking state; it clears after the last pixel of each image.
  always_ff @(posedge clk) begin
    if (rst || fire) begin
      column_count    <= '0;
      row_count       <= '0;
      min_column      <= '1;
      max_column      <= '0;
      min_row         <= '1;
      max_row         <= '0;
      has_content     <= 1'b0;
      brick_pivot_row <= '0;
    end else if (s1_go) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      min_column      <= upd_min_col;
      max_column      <= upd_max_col;
      min_row         <= upd_min_row;
      max_row         <= upd_max_row;
      has_content     <= upd_has;
      brick_pivot_row <= upd_brick_row;
    end
  end

  `SATP_ASSERT_NEXT(a_clear_after_last, fire, !has_content && column_count == '0 && row_count == '0, "tracking state not cleared after the last pixel")
  `SATP_ASSERT_NEXT(a_held_pixel_kept, s1_valid && !s1_go, s1_valid && $stable(s1_pix), "held pixel lost while the result slot was busy")

endmodule

@@ rtl/satp_result.sv @@
// Result computation and output register of the sprite trim and pivot block.
// Depends on satp_pkg and on the assertion macros header.
`include "sprite_alpha_trim_and_pivot_macros.svh"
module satp_result
  import satp_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF,
  parameter int CW            = $clog2(MAX_IMAGE_DIM),
  parameter int EW            = CW + 1
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          upd_has,
  input  logic [CW-1:0] upd_min_col,
  input  logic [CW-1:0] upd_max_col,
  input  logic [CW-1:0] upd_min_row,
  input  logic [CW-1:0] upd_max_row,
  input  logic [CW-1:0] upd_brick_row,
  input  logic [EW-1:0] w_eff,
  input  cfg_t          cfg,
  output logic          out_free,
  output logic          res_valid,
  input  logic          res_stall,
  output result_t       res
);

  localparam int XW = (EW > DIM_W) ? EW : DIM_W;

  logic [EW-1:0] bw;
  logic [EW-1:0] bh;
  logic          too_large;
  logic [31:0]   left32;
  logic [31:0]   top32;
  logic [31:0]   bw32;
  logic [31:0]   bh32;
  logic [31:0]   px32;
  logic [31:0]   py32;
  result_t       res_next;

  // The slot can take a new transaction when empty or when it drains now.
  assign out_free = !res_valid || !res_stall;

  // Box size and the texture limit check.
  assign bw = {1'b0, upd_max_col} - {1'b0, upd_min_col} + EW'(1);
  assign bh = {1'b0, upd_max_row} - {1'b0, upd_min_row} + EW'(1);
  assign too_large = (XW'(bw) > XW'(cfg.texture_width_limit))
                  || (XW'(bh) > XW'(cfg.texture_height_limit));

  assign left32 = 32'(upd_min_col);
  assign top32  = 32'(upd_min_row);
  assign bw32   = 32'(bw);
  assign bh32   = 32'(bh);

  // Pivot selection; the unused mode code falls back to the given pivot.
  always_comb begin
    unique case (cfg.pivot_mode)
      PM_BRICKS: begin
        px32 = 32'(upd_min_col);
        py32 = 32'(upd_brick_row);
      end
      PM_LOWER_MID: begin
        px32 = 32'(w_eff >> 1);
        py32 = 32'(upd_max_row);
      end
      default: begin
        px32 = 32'(unsigned'(cfg.given_pivot_x));
        py32 = 32'(unsigned'(cfg.given_pivot_y));
      end
    endcase
  end

  // An empty image reports zeros in every field but the status.
  always_comb begin
    res_next = '0;
    if (!upd_has) begin
      res_next.status = ST_EMPTY;
    end else begin
      res_next.status     = too_large ? ST_TOO_LARGE : ST_ACCEPTED;
      res_next.box_left   = left32[COORD_W-1:0];
      res_next.box_top    = top32[COORD_W-1:0];
      res_next.box_width  = bw32[DIM_W-1:0];
      res_next.box_height = bh32[DIM_W-1:0];
      res_next.pivot_x    = px32[PIVOT_W-1:0];
      res_next.pivot_y    = py32[PIVOT_W-1:0];
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  `SATP_ASSERT_NOW(a_no_overwrite, fire, !res_valid || !res_stall, "result overwritten while stalled")
  `SATP_ASSERT_NOW(a_empty_zero, res_valid && res.status == ST_EMPTY, res.box_width == '0 && res.box_height == '0 && res.pivot_x == '0 && res.pivot_y == '0, "empty result carries nonzero fields")

endmodule

@@ rtl/sprite_alpha_trim_and_pivot.sv @@
// Sprite alpha trim and pivot: bounding box of opaque pixels and pivot point.
// A last pixel passes the input register; its result goes to the output register.
// Throughput: one pixel per cycle; the tracker updates its box as a pixel moves on.
// The result register drains at the consumer's pace; a stalled result holds
// back only a last pixel. Synchronous reset clears the handshake state, the
// box tracking state and the configuration registers to their defaults.
module sprite_alpha_trim_and_pivot
  import satp_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pixel_t                pix,
  output logic                  res_valid,
  input  logic                  res_stall,
  output result_t               res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_IMAGE_DIM);
  localparam int EW = CW + 1;

  cfg_t          cfg;
  logic          out_free;
  logic          fire;
  logic          upd_has;
  logic [CW-1:0] upd_min_col;
  logic [CW-1:0] upd_max_col;
  logic [CW-1:0] upd_min_row;
  logic [CW-1:0] upd_max_row;
  logic [CW-1:0] upd_brick_row;
  logic [EW-1:0] w_eff;

  // Configuration registers.
  satp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and box tracking.
  satp_track #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .CW            (CW),
    .EW            (EW)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pix           (pix),
    .cfg           (cfg),
    .out_free      (out_free),
    .fire          (fire),
    .upd_has       (upd_has),
    .upd_min_col   (upd_min_col),
    .upd_max_col   (upd_max_col),
    .upd_min_row   (upd_min_row),
    .upd_max_row   (upd_max_row),
    .upd_brick_row (upd_brick_row),
    .w_eff         (w_eff)
  );

  // Result formatting and output register.
  satp_result #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .CW            (CW),
    .EW            (EW)
  ) u_result (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .upd_has       (upd_has),
    .upd_min_col   (upd_min_col),
    .upd_max_col   (upd_max_col),
    .upd_min_row   (upd_min_row),
    .upd_max_row   (upd_max_row),
    .upd_brick_row (upd_brick_row),
    .w_eff         (w_eff),
    .cfg           (cfg),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res)
  );

endmodule
